// ===== rtl/lse_pkg.sv =====
// shared types, constants and register map for the lsb stego embed/extract block
package lse_pkg;

    localparam int LENGTH_FIELD_BITS = 32;
    localparam int SIG_BITS          = 24;
    localparam int HDR_BITS          = 33 + LENGTH_FIELD_BITS;
    localparam int HDR_IDX_W         = $clog2(HDR_BITS);
    localparam int POS_W             = 36;
    localparam int ADDR_W            = 5;
    localparam int DATA_W            = 32;

    localparam logic [SIG_BITS-1:0] SIGNATURE = 24'h435954;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SMALL    = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;

    localparam logic [2:0] REG_DIRECTION      = 3'd0;
    localparam logic [2:0] REG_EMBED_SYSTEM   = 3'd1;
    localparam logic [2:0] REG_EMBED_SPACING  = 3'd2;
    localparam logic [2:0] REG_MESSAGE_LENGTH = 3'd3;
    localparam logic [2:0] REG_CARRIER_LENGTH = 3'd4;

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [7:0] carrier_byte;
        logic [7:0] message_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  carrier_out;
        logic [7:0]  revealed_byte;
        logic        revealed_valid;
        logic [2:0]  found_system;
        logic [5:0]  found_spacing;
        logic [31:0] found_length;
        logic        header_complete;
        logic        message_complete;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic        direction;
        logic [2:0]  embed_system;
        logic [5:0]  embed_spacing;
        logic [31:0] message_length;
        logic [30:0] carrier_length;
    } t_cfg;

endpackage

// ===== rtl/lse_core.sv =====
// per-item embed/extract datapath with frame state registers
module lse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  lse_pkg::t_in_item  i_item,
    input  lse_pkg::t_cfg      i_cfg,
    output lse_pkg::t_out_item o_result
);
    import lse_pkg::*;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_held, n_held;
    logic [31:0] r_gs, n_gs;
    logic [2:0]  r_sys, n_sys;
    logic [5:0]  r_spc, n_spc;
    logic [31:0] r_len, n_len;
    logic [1:0]  r_fail, n_fail;

    t_pos                  pos0;
    t_pos                  pos_inc;
    logic [31:0]           gs0;
    logic [2:0]            sys0;
    logic [5:0]            spc0;
    logic [31:0]           len0;
    logic [1:0]            fail0;
    t_pos                  total_e;
    t_pos                  total_x;
    logic                  too_small;
    logic [HDR_BITS-1:0]   hdr_vec;
    logic [HDR_IDX_W-1:0]  hdr_idx;
    logic [2:0]            q3;
    logic [7:0]            byte_sel;
    logic                  emb_bit;
    t_out_item             res;

    always_comb begin
        pos0    = i_item.frame_start ? '0 : r_pos;
        gs0     = i_item.frame_start ? '0 : r_gs;
        sys0    = i_item.frame_start ? '0 : r_sys;
        spc0    = i_item.frame_start ? '0 : r_spc;
        len0    = i_item.frame_start ? '0 : r_len;
        fail0   = i_item.frame_start ? STAT_OK : r_fail;
        pos_inc = pos0 + t_pos'(1);

        total_e   = t_pos'({i_cfg.message_length, 3'b000}) + t_pos'(HDR_BITS);
        total_x   = t_pos'({len0, 3'b000}) + t_pos'(HDR_BITS);
        too_small = t_pos'(i_cfg.carrier_length) <= total_e;

        hdr_vec  = {SIGNATURE, i_cfg.embed_system, i_cfg.embed_spacing,
                    i_cfg.message_length[LENGTH_FIELD_BITS-1:0]};
        hdr_idx  = HDR_IDX_W'(HDR_BITS - 1) - pos0[HDR_IDX_W-1:0];
        q3       = pos0[2:0] - 3'(HDR_BITS);
        byte_sel = (q3 == 3'd0) ? i_item.message_byte : r_held;
        emb_bit  = (pos0 < t_pos'(HDR_BITS)) ? hdr_vec[hdr_idx] : byte_sel[3'd7 - q3];

        n_pos  = pos0;
        n_held = r_held;
        n_gs   = gs0;
        n_sys  = sys0;
        n_spc  = spc0;
        n_len  = len0;
        n_fail = fail0;

        res             = '0;
        res.carrier_out = i_item.carrier_byte;

        if (!i_cfg.direction) begin
            if (too_small) begin
                res.status = STAT_SMALL;
            end else begin
                if (pos0 < total_e) begin
                    if (pos0 >= t_pos'(HDR_BITS) && q3 == 3'd0) begin
                        n_held = i_item.message_byte;
                    end
                    res.carrier_out      = {i_item.carrier_byte[7:1], emb_bit};
                    res.message_complete = (pos_inc == total_e);
                    n_pos                = pos_inc;
                end
                res.header_complete = (n_pos >= t_pos'(HDR_BITS));
            end
        end else begin
            if (fail0 != STAT_MISMATCH &&
                (pos0 < t_pos'(HDR_BITS) || pos0 < total_x)) begin
                n_gs = {gs0[30:0], i_item.carrier_byte[0]};
                if (pos0 == t_pos'(SIG_BITS - 1) && n_gs[SIG_BITS-1:0] != SIGNATURE) begin
                    n_fail = STAT_MISMATCH;
                end else begin
                    if (pos0 == t_pos'(SIG_BITS + 2)) begin
                        n_sys = n_gs[2:0];
                    end else if (pos0 == t_pos'(SIG_BITS + 8)) begin
                        n_spc = n_gs[5:0];
                    end else if (pos0 == t_pos'(HDR_BITS - 1)) begin
                        n_len = 32'(n_gs[LENGTH_FIELD_BITS-1:0]);
                    end
                    if (pos0 >= t_pos'(HDR_BITS)) begin
                        if (q3 == 3'd7) begin
                            res.revealed_byte  = n_gs[7:0];
                            res.revealed_valid = 1'b1;
                        end
                        res.message_complete = (pos_inc == total_x);
                    end
                    n_pos = pos_inc;
                end
            end
            res.found_system    = n_sys;
            res.found_spacing   = n_spc;
            res.found_length    = n_len;
            res.header_complete = (n_fail != STAT_MISMATCH) && (n_pos >= t_pos'(HDR_BITS));
            res.status          = n_fail;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_held <= '0;
            r_gs   <= '0;
            r_sys  <= '0;
            r_spc  <= '0;
            r_len  <= '0;
            r_fail <= STAT_OK;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_held <= n_held;
            r_gs   <= n_gs;
            r_sys  <= n_sys;
            r_spc  <= n_spc;
            r_len  <= n_len;
            r_fail <= n_fail;
        end
    end

endmodule

// ===== rtl/lsb_stego_embed_extract.sv =====
// top level: handshake stages, configuration registers and the stego datapath
// Takes one carrier byte per clock while the output side is not stalled and returns one
// result item per carrier byte, in order: the item is captured in an input register, the bit
// substitution or capture runs in a single combinational pass against the frame state, and the
// result lands in an output register. Throughput is one item per cycle, set by that single pass;
// a stalled output only holds the pipeline, nothing is lost. Registers are written through the
// APB-style port (direction, system, spacing, message length, carrier length at byte offsets
// 0, 4, 8, 12, 16) by the user only while no item is in flight; the block does not enforce it.
module lsb_stego_embed_extract (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lse_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lse_pkg::t_out_item                  o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lse_pkg::ADDR_W-1:0]          paddr,
    input  logic [lse_pkg::DATA_W-1:0]          pwdata,
    output logic [lse_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import lse_pkg::*;

    t_cfg      r_cfg, n_cfg;
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;
    t_out_item core_res;
    logic      advance;
    logic      in_accept;
    logic      cfg_write;
    logic [2:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_write) begin
            unique case (reg_idx)
                REG_DIRECTION:      n_cfg.direction      = pwdata[0];
                REG_EMBED_SYSTEM:   n_cfg.embed_system   = pwdata[2:0];
                REG_EMBED_SPACING:  n_cfg.embed_spacing  = pwdata[5:0];
                REG_MESSAGE_LENGTH: n_cfg.message_length = pwdata[31:0];
                REG_CARRIER_LENGTH: n_cfg.carrier_length = pwdata[30:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DIRECTION:      prdata = DATA_W'(r_cfg.direction);
            REG_EMBED_SYSTEM:   prdata = DATA_W'(r_cfg.embed_system);
            REG_EMBED_SPACING:  prdata = DATA_W'(r_cfg.embed_spacing);
            REG_MESSAGE_LENGTH: prdata = DATA_W'(r_cfg.message_length);
            REG_CARRIER_LENGTH: prdata = DATA_W'(r_cfg.carrier_length);
            default:            prdata = '0;
        endcase
    end

    // pipeline handshake
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_accept   = i_in_valid && o_in_ready;
    assign n_in_valid  = in_accept || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !i_out_ready);

    lse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a held input item is never dropped while the output side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("input stage lost an item");

    // a mismatch never reports a finished header or a body byte
    a_mismatch_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == STAT_MISMATCH |->
            !o_out.header_complete && !o_out.revealed_valid)
        else $error("body output after signature mismatch");

    // body bytes only in extract mode, with the carrier byte passed through unchanged
    a_reveal_extract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && core_res.revealed_valid |-> r_cfg.direction
            && core_res.carrier_out == r_in.carrier_byte)
        else $error("revealed byte outside extract mode");

endmodule
